[hw/rtl/necd_pkg.sv]
// ----------------------------------------------------------------------------
// necd_pkg: shared types and constants of the NEC IR frame decoder
// Phase codes, register indexes, tolerance margins, result word and the
// tolerance window compare.
// ----------------------------------------------------------------------------
`default_nettype none

package necd_pkg;

  localparam int unsigned DurW   = 16;
  localparam int unsigned TolW   = 11;
  localparam int unsigned NumReg = 6;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned NumBit = 32;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_REPEAT,
    PH_DATA,
    PH_DONE
  } phase_e;

  typedef enum logic [IdxW-1:0] {
    REG_LEADER_PULSE = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_REPEAT_SPACE = 3'd2,
    REG_BIT_PULSE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_SPACE    = 3'd5
  } cfg_idx_e;

  localparam logic [TolW-1:0] TolLeaderPulse = 11'd1200;
  localparam logic [TolW-1:0] TolLeaderSpace = 11'd700;
  localparam logic [TolW-1:0] TolRepeatSpace = 11'd500;
  localparam logic [TolW-1:0] TolBitPulse    = 11'd300;
  localparam logic [TolW-1:0] TolZeroSpace   = 11'd350;
  localparam logic [TolW-1:0] TolOneSpace    = 11'd450;

  localparam logic [DurW-1:0] RstLeaderPulse = 16'd9000;
  localparam logic [DurW-1:0] RstLeaderSpace = 16'd4500;
  localparam logic [DurW-1:0] RstRepeatSpace = 16'd2250;
  localparam logic [DurW-1:0] RstBitPulse    = 16'd560;
  localparam logic [DurW-1:0] RstZeroSpace   = 16'd560;
  localparam logic [DurW-1:0] RstOneSpace    = 16'd1690;

  typedef logic [NumReg-1:0][DurW-1:0] nominal_t;

  typedef struct packed {
    logic        frame_ok;
    logic        is_repeat;
    logic        check_ok;
    logic        extended_address;
    logic [5:0]  bit_count;
    logic [15:0] address;
    logic [7:0]  command;
    logic [31:0] raw_word;
  } res_t;

  // d in [nom - tol, nom + tol], lower bound clamps at zero
  function automatic logic dur_match(logic [DurW-1:0] d, logic [DurW-1:0] nom,
                                     logic [TolW-1:0] tol);
    logic [DurW-1:0] lo;
    logic [DurW:0]   hi;
    logic [DurW-1:0] tol_x;
    tol_x = {{(DurW-TolW){1'b0}}, tol};
    lo    = (nom > tol_x) ? (nom - tol_x) : '0;
    hi    = {1'b0, nom} + {1'b0, tol_x};
    return (d >= lo) && ({1'b0, d} <= hi);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/necd_seg_if.sv]
// ----------------------------------------------------------------------------
// necd_seg_if: segment channel
// One mark or space segment per word: level, duration, last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface necd_seg_if;
  logic        valid;
  logic        ready;
  logic        level;
  logic [15:0] duration;
  logic        last;

  modport source (output valid, output level, output duration, output last,
                  input ready);
  modport sink   (input valid, input level, input duration, input last,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/necd_res_if.sv]
// ----------------------------------------------------------------------------
// necd_res_if: result channel
// One decoded frame summary per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface necd_res_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic        is_repeat;
  logic        check_ok;
  logic        extended_address;
  logic [5:0]  bit_count;
  logic [15:0] address;
  logic [7:0]  command;
  logic [31:0] raw_word;

  modport source (output valid, output frame_ok, output is_repeat, output check_ok,
                  output extended_address, output bit_count, output address,
                  output command, output raw_word, input ready);
  modport sink   (input valid, input frame_ok, input is_repeat, input check_ok,
                  input extended_address, input bit_count, input address,
                  input command, input raw_word, output ready);
endinterface

`default_nettype wire

[hw/rtl/necd_core.sv]
// ----------------------------------------------------------------------------
// necd_core: frame state and per-segment decode
// Leader search, repeat check, bit assembly and the decided frame summary.
// Result for the current segment is combinational; state moves on step_i.
// ----------------------------------------------------------------------------
`default_nettype none

module necd_core import necd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            level_i,
  input  wire logic [DurW-1:0] duration_i,
  input  wire logic            last_i,
  input  wire nominal_t        nominal_i,
  output res_t                 res_o
);

  phase_e            phase_q, phase_d;
  logic              prev_level_q, prev_level_d;
  logic [DurW-1:0]   prev_dur_q, prev_dur_d;
  logic              have_prev_q, have_prev_d;
  logic [5:0]        bit_idx_q, bit_idx_d;
  logic              expect_space_q, expect_space_d;
  logic [NumBit-1:0] shift_q, shift_d;
  res_t              dec_q, dec_d;

  logic in_lp, in_ls, in_rs, in_bp, in_zs, in_os;
  logic [5:0] bit_idx_inc;

  assign in_lp = dur_match(prev_dur_q, nominal_i[REG_LEADER_PULSE], TolLeaderPulse);
  assign in_ls = dur_match(duration_i, nominal_i[REG_LEADER_SPACE], TolLeaderSpace);
  assign in_rs = dur_match(duration_i, nominal_i[REG_REPEAT_SPACE], TolRepeatSpace);
  assign in_bp = dur_match(duration_i, nominal_i[REG_BIT_PULSE],    TolBitPulse);
  assign in_zs = dur_match(duration_i, nominal_i[REG_ZERO_SPACE],   TolZeroSpace);
  assign in_os = dur_match(duration_i, nominal_i[REG_ONE_SPACE],    TolOneSpace);
  assign bit_idx_inc = bit_idx_q + 6'd1;

  function automatic res_t finish_word(logic [NumBit-1:0] w);
    res_t r;
    logic cmd_good;
    cmd_good           = (w[31:24] == ~w[23:16]);
    r                  = '0;
    r.frame_ok         = 1'b1;
    r.bit_count        = 6'(NumBit);
    r.raw_word         = w;
    r.command          = w[23:16];
    r.address          = {8'd0, w[7:0]};
    if ((w[15:8] == ~w[7:0]) && cmd_good) begin
      r.check_ok = 1'b1;
    end else if (cmd_good) begin
      r.extended_address = 1'b1;
      r.address          = w[15:0];
    end
    return r;
  endfunction

  always_comb begin
    phase_d        = phase_q;
    prev_level_d   = prev_level_q;
    prev_dur_d     = prev_dur_q;
    have_prev_d    = have_prev_q;
    bit_idx_d      = bit_idx_q;
    expect_space_d = expect_space_q;
    shift_d        = shift_q;
    dec_d          = dec_q;

    case (phase_q)
      PH_SEEK: begin
        if (have_prev_q && (level_i != prev_level_q) && in_lp) begin
          if (in_rs) begin
            phase_d = PH_REPEAT;
          end else if (in_ls) begin
            phase_d        = PH_DATA;
            bit_idx_d      = '0;
            expect_space_d = 1'b0;
            shift_d        = '0;
          end
        end
        prev_level_d = level_i;
        prev_dur_d   = duration_i;
        have_prev_d  = 1'b1;
      end
      PH_REPEAT: begin
        dec_d           = '0;
        dec_d.frame_ok  = in_bp;
        dec_d.is_repeat = in_bp;
        phase_d         = PH_DONE;
      end
      PH_DATA: begin
        if (!expect_space_q) begin
          if (in_bp) begin
            expect_space_d = 1'b1;
          end else begin
            dec_d   = '0;
            phase_d = PH_DONE;
          end
        end else begin
          expect_space_d = 1'b0;
          if (!in_zs && !in_os) begin
            dec_d   = '0;
            phase_d = PH_DONE;
          end else begin
            // zero window wins when both match
            if (!in_zs) begin
              shift_d = shift_q | (NumBit'(1) << bit_idx_q[4:0]);
            end
            bit_idx_d = bit_idx_inc;
            if (bit_idx_inc >= 6'(NumBit)) begin
              dec_d   = finish_word(shift_d);
              phase_d = PH_DONE;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res_o = (phase_d == PH_DONE) ? dec_d : '0;

    // frame boundary: back to seeking
    if (last_i) begin
      phase_d        = PH_SEEK;
      prev_level_d   = 1'b0;
      prev_dur_d     = '0;
      have_prev_d    = 1'b0;
      bit_idx_d      = '0;
      expect_space_d = 1'b0;
      shift_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_SEEK;
      prev_level_q   <= 1'b0;
      prev_dur_q     <= '0;
      have_prev_q    <= 1'b0;
      bit_idx_q      <= '0;
      expect_space_q <= 1'b0;
      shift_q        <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      prev_level_q   <= prev_level_d;
      prev_dur_q     <= prev_dur_d;
      have_prev_q    <= have_prev_d;
      bit_idx_q      <= bit_idx_d;
      expect_space_q <= expect_space_d;
      shift_q        <= shift_d;
    end
  end

  // only read in PH_DONE, which always loads it first
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      dec_q <= dec_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/nec_ir_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_unit: NEC IR frame decoder, one segment per word
// Usage:
//   seg_i carries one mark or space segment per word (level, duration in
//   microseconds, last). res_o carries one frame summary per frame, issued
//   for the word that has last set; other words give no result.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the six nominal timings (index 0..5,
//   leader pulse, leader space, repeat space, bit pulse, zero space, one
//   space); other indexes are dropped. Write only while the block is idle.
// Timing:
//   A segment word is held in the input register, is decoded there
//   by compare logic and the frame state, and a result lands in the output
//   register. One segment per cycle is sustained unless a last segment
//   stalls (see Stall); these are the only two stages.
// Reset:
//   Nominals return to 9000/4500/2250/560/560/1690 us, the decoder seeks a
//   leader and both registers are empty.
// Stall:
//   While a result waits, segments without last keep flowing; a last
//   segment holds in the input register, with seg_i.ready low, until the
//   result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_frame_decoder_unit import necd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_idx_i,
  input  wire logic [DurW-1:0] cfg_data_i,
  necd_seg_if.sink             seg_i,
  necd_res_if.source           res_o
);

  nominal_t nominal_q;

  logic            s1_valid_q;
  logic            s1_level_q;
  logic [DurW-1:0] s1_dur_q;
  logic            s1_last_q;
  logic            s1_go;
  logic            seg_fire;

  logic            out_valid_q;
  res_t            out_q;
  res_t            core_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q[REG_LEADER_PULSE] <= RstLeaderPulse;
      nominal_q[REG_LEADER_SPACE] <= RstLeaderSpace;
      nominal_q[REG_REPEAT_SPACE] <= RstRepeatSpace;
      nominal_q[REG_BIT_PULSE]    <= RstBitPulse;
      nominal_q[REG_ZERO_SPACE]   <= RstZeroSpace;
      nominal_q[REG_ONE_SPACE]    <= RstOneSpace;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_LEADER_PULSE: nominal_q[REG_LEADER_PULSE] <= cfg_data_i;
        REG_LEADER_SPACE: nominal_q[REG_LEADER_SPACE] <= cfg_data_i;
        REG_REPEAT_SPACE: nominal_q[REG_REPEAT_SPACE] <= cfg_data_i;
        REG_BIT_PULSE:    nominal_q[REG_BIT_PULSE]    <= cfg_data_i;
        REG_ZERO_SPACE:   nominal_q[REG_ZERO_SPACE]   <= cfg_data_i;
        REG_ONE_SPACE:    nominal_q[REG_ONE_SPACE]    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // a last word needs a free result slot, others always move on
  assign s1_go       = s1_valid_q && (!s1_last_q || !out_valid_q || res_o.ready);
  assign seg_i.ready = !s1_valid_q || s1_go;
  assign seg_fire    = seg_i.valid && seg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (seg_i.ready) begin
      s1_valid_q <= seg_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_fire) begin
      s1_level_q <= seg_i.level;
      s1_dur_q   <= seg_i.duration;
      s1_last_q  <= seg_i.last;
    end
  end

  necd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_go),
    .level_i    (s1_level_q),
    .duration_i (s1_dur_q),
    .last_i     (s1_last_q),
    .nominal_i  (nominal_q),
    .res_o      (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.frame_ok         = out_q.frame_ok;
  assign res_o.is_repeat        = out_q.is_repeat;
  assign res_o.check_ok         = out_q.check_ok;
  assign res_o.extended_address = out_q.extended_address;
  assign res_o.bit_count        = out_q.bit_count;
  assign res_o.address          = out_q.address;
  assign res_o.command          = out_q.command;
  assign res_o.raw_word         = out_q.raw_word;

endmodule

`default_nettype wire

[hw/rtl/necd_checker.sv]
// ----------------------------------------------------------------------------
// necd_checker: port-level checks of the NEC IR frame decoder
// Result channel handshake and consistency of the frame summary fields.
// ----------------------------------------------------------------------------
`default_nettype none

module necd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        frame_ok_i,
  input wire logic        is_repeat_i,
  input wire logic        check_ok_i,
  input wire logic        extended_address_i,
  input wire logic [5:0]  bit_count_i,
  input wire logic [15:0] address_i,
  input wire logic [7:0]  command_i,
  input wire logic [31:0] raw_word_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(raw_word_i) && $stable(address_i)
                                    && $stable(frame_ok_i) && $stable(is_repeat_i))
    else $error("result word changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_ok_i |-> !is_repeat_i && !check_ok_i && !extended_address_i
                                   && bit_count_i == 6'd0 && address_i == 16'd0
                                   && command_i == 8'd0 && raw_word_i == 32'd0)
    else $error("failed frame carries nonzero fields");

  a_repeat_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_repeat_i |-> frame_ok_i && bit_count_i == 6'd0
                                   && raw_word_i == 32'd0
                                   && !check_ok_i && !extended_address_i)
    else $error("repeat frame carries data fields");

  a_check_forms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (check_ok_i || extended_address_i) |->
      !(check_ok_i && extended_address_i) && bit_count_i == 6'd32
      && command_i == raw_word_i[23:16])
    else $error("address check flags inconsistent with data frame");

endmodule

bind nec_ir_frame_decoder_unit necd_checker u_necd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (res_o.valid),
  .out_ready_i        (res_o.ready),
  .frame_ok_i         (res_o.frame_ok),
  .is_repeat_i        (res_o.is_repeat),
  .check_ok_i         (res_o.check_ok),
  .extended_address_i (res_o.extended_address),
  .bit_count_i        (res_o.bit_count),
  .address_i          (res_o.address),
  .command_i          (res_o.command),
  .raw_word_i         (res_o.raw_word)
);

`default_nettype wire
